// ===== sv/alti_pkg.sv =====
package alti_pkg;

	// classified character as it travels from front to back
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_SPACE = 2'd1,
		KIND_END   = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] ch;
	} item_t;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_COUNT   = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// mnemonics, first character in the low byte
	localparam logic [31:0] MN_ADD  = 32'h0064_6461;
	localparam logic [31:0] MN_SUB  = 32'h0062_7573;
	localparam logic [31:0] MN_LW   = 32'h0000_776c;
	localparam logic [31:0] MN_SW   = 32'h0000_7773;
	localparam logic [31:0] MN_BEQZ = 32'h7a71_6562;
	localparam logic [31:0] MN_ADDI = 32'h6964_6461;

	// encodings
	localparam logic [5:0] FUNCT_ADD = 6'h20;
	localparam logic [5:0] FUNCT_SUB = 6'h22;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2b;
	localparam logic [5:0] OPC_BEQZ  = 6'h06;
	localparam logic [5:0] OPC_ADDI  = 6'h0c;

endpackage

// ===== sv/alti_front.sv =====
module alti_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     text_char,
	input  logic           line_end,
	output logic           item_valid,
	output alti_pkg::item_t item,
	input  logic           item_take
);
	import alti_pkg::*;

	item_t      fold;
	logic       wr_en;
	logic       rd_en;
	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	// fold case and classify
	always_comb begin
		fold.ch   = text_char;
		fold.kind = KIND_CHAR;
		if (text_char >= CH_UP_A && text_char <= CH_UP_Z) begin
			fold.ch = text_char | 8'h20;
		end
		if (line_end) begin
			fold.kind = KIND_END;
		end else if (text_char == CH_SPACE) begin
			fold.kind = KIND_SPACE;
		end
	end

	assign full       = (count_q == 2'd2);
	assign wr_en      = push && !full;
	assign item_valid = (count_q != 2'd0);
	assign rd_en      = item_take && item_valid;
	assign item       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= fold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// ===== sv/alti_back.sv =====
module alti_back #(
	parameter int MNEMONIC_CHARS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  alti_pkg::item_t item,
	output logic            item_take,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     instruction_word,
	output logic [1:0]      status
);
	import alti_pkg::*;

	localparam int MNW   = 8 * MNEMONIC_CHARS;
	localparam int LEN_W = $clog2(MNEMONIC_CHARS + 1);

	typedef enum logic [2:0] {
		MOP_NONE, MOP_ADD, MOP_SUB, MOP_LW, MOP_SW, MOP_BEQZ, MOP_ADDI
	} mop_t;

	// parser state
	logic [MNW-1:0]   mn_q;
	logic [LEN_W-1:0] mn_len_q;
	logic             mn_ovf_q;
	logic [2:0]       tc_q;
	logic             in_tok_q;
	logic [1:0]       cp_q;
	logic [4:0]       reg_q;
	logic             reg_neg_q;
	logic [15:0]      imm_q;
	logic             imm_neg_q;
	logic [15:0]      off_q;
	logic             pfx_q;
	logic [4:0]       base_q;
	logic [4:0]       sr_q [3];
	logic [15:0]      sm_q [3];
	logic [20:0]      sob_q;
	logic             out_valid_q;
	logic [31:0]      word_q;
	logic [1:0]       status_q;

	// next values
	logic [MNW-1:0]   mn_n;
	logic [LEN_W-1:0] mn_len_n;
	logic             mn_ovf_n;
	logic [2:0]       tc_e;
	logic [1:0]       cp_e, cp_n;
	logic [4:0]       reg_e, reg_n;
	logic             reg_neg_e, reg_neg_n;
	logic [15:0]      imm_e, imm_n;
	logic             imm_neg_e, imm_neg_n;
	logic [15:0]      off_e, off_n;
	logic             pfx_e, pfx_n;
	logic [4:0]       base_e, base_n;
	logic [4:0]       sr_n [3];
	logic [15:0]      sm_n [3];
	logic [20:0]      sob_n;
	logic             start, fin, is_digit, take_end;
	logic [7:0]       ch;
	logic [1:0]       slot;
	mop_t             mop;
	logic [2:0]       need;
	logic [31:0]      word_n;
	logic [1:0]       status_n;

	assign ch       = item.ch;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign empty    = !out_valid_q;
	assign instruction_word = word_q;
	assign status   = status_q;

	// a line end needs the result slot; characters always flow
	assign item_take = item_valid && (item.kind != KIND_END || !out_valid_q || pop);
	assign take_end  = item_take && (item.kind == KIND_END);

	// character step: token start clears the per-token state first
	always_comb begin
		start     = (item.kind == KIND_CHAR) && !in_tok_q;
		tc_e      = (start && tc_q != 3'd7) ? tc_q + 3'd1 : tc_q;
		cp_e      = start ? 2'd0  : cp_q;
		reg_e     = start ? 5'd0  : reg_q;
		reg_neg_e = start ? 1'b0  : reg_neg_q;
		imm_e     = start ? 16'd0 : imm_q;
		imm_neg_e = start ? 1'b0  : imm_neg_q;
		off_e     = start ? 16'd0 : off_q;
		pfx_e     = start ? 1'b1  : pfx_q;
		base_e    = start ? 5'd0  : base_q;

		mn_n     = mn_q;
		mn_len_n = mn_len_q;
		mn_ovf_n = mn_ovf_q;
		if (tc_e == 3'd1 && !mn_ovf_q) begin
			if (ch == CH_NUL || mn_len_q >= LEN_W'(MNEMONIC_CHARS)) begin
				mn_ovf_n = 1'b1;
			end else begin
				for (int i = 0; i < MNEMONIC_CHARS; i++) begin
					if (LEN_W'(i) == mn_len_q) begin
						mn_n[8*i +: 8] = ch;
					end
				end
				mn_len_n = mn_len_q + LEN_W'(1);
			end
		end

		// register operand: first character skipped, arithmetic mod 32
		reg_n     = reg_e;
		reg_neg_n = reg_neg_e;
		if (cp_e == 2'd1 && ch == CH_MINUS) begin
			reg_neg_n = 1'b1;
		end else if (cp_e != 2'd0) begin
			reg_n = reg_e * 5'd10 + ch[4:0] - 5'd16;
		end

		imm_n     = imm_e;
		imm_neg_n = imm_neg_e;
		if (cp_e == 2'd0 && ch == CH_MINUS) begin
			imm_neg_n = 1'b1;
		end else begin
			imm_n = imm_e * 16'd10 + {8'd0, ch} - 16'd48;
		end

		// off(base): leading digits are the offset, later digits the base
		off_n  = off_e;
		pfx_n  = pfx_e;
		base_n = base_e;
		if (pfx_e) begin
			if (is_digit) begin
				off_n = off_e * 16'd10 + {8'd0, ch} - 16'd48;
			end else begin
				pfx_n = 1'b0;
			end
		end else if (is_digit) begin
			base_n = base_e * 5'd10 + ch[4:0] - 5'd16;
		end

		cp_n = (cp_e == 2'd2) ? 2'd2 : cp_e + 2'd1;
	end

	// token close: save operands of tokens two to four
	always_comb begin
		fin   = in_tok_q && (item.kind == KIND_SPACE || item.kind == KIND_END);
		slot  = 2'(tc_q - 3'd2);
		sr_n  = sr_q;
		sm_n  = sm_q;
		sob_n = sob_q;
		if (fin && tc_q >= 3'd2 && tc_q <= 3'd4) begin
			sr_n[slot] = reg_neg_q ? 5'd0 - reg_q : reg_q;
			sm_n[slot] = imm_neg_q ? 16'd0 - imm_q : imm_q;
			if (tc_q == 3'd3) begin
				sob_n = {off_q, base_q};
			end
		end
	end

	// decode and encode at line end
	always_comb begin
		mop  = MOP_NONE;
		need = 3'd0;
		if (mn_q == MNW'(MN_ADD)) begin
			mop = MOP_ADD;  need = 3'd4;
		end else if (mn_q == MNW'(MN_SUB)) begin
			mop = MOP_SUB;  need = 3'd4;
		end else if (mn_q == MNW'(MN_LW)) begin
			mop = MOP_LW;   need = 3'd3;
		end else if (mn_q == MNW'(MN_SW)) begin
			mop = MOP_SW;   need = 3'd3;
		end else if (mn_q == MNW'(MN_BEQZ)) begin
			mop = MOP_BEQZ; need = 3'd3;
		end else if (mn_q == MNW'(MN_ADDI)) begin
			mop = MOP_ADDI; need = 3'd4;
		end

		priority if (tc_q == 3'd0) begin
			status_n = ST_EMPTY;
		end else if (mn_ovf_q || mop == MOP_NONE) begin
			status_n = ST_UNKNOWN;
		end else if (tc_q != need) begin
			status_n = ST_COUNT;
		end else begin
			status_n = ST_OK;
		end

		word_n = 32'd0;
		if (status_n == ST_OK) begin
			unique case (mop)
				MOP_ADD:  word_n = {6'd0, sr_n[1], sr_n[2], sr_n[0], 5'd0, FUNCT_ADD};
				MOP_SUB:  word_n = {6'd0, sr_n[1], sr_n[2], sr_n[0], 5'd0, FUNCT_SUB};
				MOP_LW:   word_n = {OPC_LW, sob_n[4:0], sr_n[0], sob_n[20:5]};
				MOP_SW:   word_n = {OPC_SW, sob_n[4:0], sr_n[0], sob_n[20:5]};
				MOP_BEQZ: word_n = {OPC_BEQZ, sr_n[0], 5'd0, sm_n[1]};
				MOP_ADDI: word_n = {OPC_ADDI, sr_n[1], sr_n[0], sm_n[2]};
				default:  word_n = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_end) begin
			word_q   <= word_n;
			status_q <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mn_q        <= '0;
			mn_len_q    <= '0;
			mn_ovf_q    <= 1'b0;
			tc_q        <= 3'd0;
			in_tok_q    <= 1'b0;
			cp_q        <= 2'd0;
			reg_q       <= 5'd0;
			reg_neg_q   <= 1'b0;
			imm_q       <= 16'd0;
			imm_neg_q   <= 1'b0;
			off_q       <= 16'd0;
			pfx_q       <= 1'b1;
			base_q      <= 5'd0;
			sr_q        <= '{default: '0};
			sm_q        <= '{default: '0};
			sob_q       <= 21'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (item_take) begin
				unique case (item.kind)
					KIND_CHAR: begin
						in_tok_q  <= 1'b1;
						tc_q      <= tc_e;
						mn_q      <= mn_n;
						mn_len_q  <= mn_len_n;
						mn_ovf_q  <= mn_ovf_n;
						cp_q      <= cp_n;
						reg_q     <= reg_n;
						reg_neg_q <= reg_neg_n;
						imm_q     <= imm_n;
						imm_neg_q <= imm_neg_n;
						off_q     <= off_n;
						pfx_q     <= pfx_n;
						base_q    <= base_n;
					end
					KIND_SPACE: begin
						in_tok_q <= 1'b0;
						sr_q     <= sr_n;
						sm_q     <= sm_n;
						sob_q    <= sob_n;
					end
					KIND_END: begin
						out_valid_q <= 1'b1;
						mn_q        <= '0;
						mn_len_q    <= '0;
						mn_ovf_q    <= 1'b0;
						tc_q        <= 3'd0;
						in_tok_q    <= 1'b0;
						cp_q        <= 2'd0;
						reg_q       <= 5'd0;
						reg_neg_q   <= 1'b0;
						imm_q       <= 16'd0;
						imm_neg_q   <= 1'b0;
						off_q       <= 16'd0;
						pfx_q       <= 1'b1;
						base_q      <= 5'd0;
						sr_q        <= '{default: '0};
						sm_q        <= '{default: '0};
						sob_q       <= 21'd0;
					end
					default: begin
						in_tok_q <= in_tok_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/assembly_line_to_instruction_word.sv =====
// Line assembler for add, sub, lw, sw, beqz and addi.
// Input channel (push/full): one transaction per character of a text line,
// text_char with line_end low; a transaction with line_end high closes the
// line (text_char is then ignored). Upper case folds to lower, spaces split
// tokens, lw/sw take an off(base) operand.
// Result channel (empty/pop): one transaction per closed line, carrying the
// 32-bit instruction_word and status (0 ok, 1 unknown mnemonic, 2 wrong
// operand count, 3 empty line); the word is zero unless status is ok.
// Throughput: one character per cycle, sustained. The front stage folds and
// classifies each character into a two-entry queue; the back stage parses
// one queued entry per cycle with parallel multiply-by-ten accumulates.
// Line end path: a line end accepted into the queue is taken by the back stage
// once the result register is free or being popped, and empty then goes low.
// Stall: the result register holds one line. While it is not popped, the back
// stage still parses characters of the next line and stops only at the next
// line end; that line end waits in the queue and full rises after one more
// transaction.
// Reset (arst_n low, asynchronous): queue emptied, parser cleared, no result.
module assembly_line_to_instruction_word #(
	parameter int MNEMONIC_CHARS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_char,
	input  logic        line_end,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] instruction_word,
	output logic [1:0]  status
);
	import alti_pkg::*;

	logic  item_valid;
	logic  item_take;
	item_t item;

	alti_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_char  (text_char),
		.line_end   (line_end),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	alti_back #(
		.MNEMONIC_CHARS (MNEMONIC_CHARS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item             (item),
		.item_take        (item_take),
		.empty            (empty),
		.pop              (pop),
		.instruction_word (instruction_word),
		.status           (status)
	);

	// any failing status carries a zero word
	a_err_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (instruction_word == 32'd0))
		else $error("nonzero word with failing status");

	// a full queue always has a head entry for the back stage
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> item_valid)
		else $error("queue full without a head entry");

	// a consumed line end always yields a visible result
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item.kind == KIND_END) |=> !empty)
		else $error("line end consumed without a result");

	// the back stage never takes a line end into an occupied, unpopped slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item.kind == KIND_END) |-> (empty || pop))
		else $error("result overwritten before pop");

endmodule
